### sv/camera_object_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CAMERA_OBJECT_FRAME_PARSER_DEFINES_SVH
`define CAMERA_OBJECT_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define COFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define COFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cofp_pkg.sv
// Shared widths, sync bytes, register indexes and result type of the frame parser.
// No dependencies.
package cofp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned LimitW = 6;
  localparam int unsigned NumWords = 7;

  // Sync pattern bytes
  localparam logic [ByteW-1:0] SYNC_A    = 8'h55;
  localparam logic [ByteW-1:0] SYNC_B    = 8'hAA;
  localparam logic [ByteW-1:0] SYNC_CODE = 8'h56;

  localparam logic [LimitW-1:0] LIMIT_RESET = 6'd50;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_MODE    = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ATTEMPT_LIMIT = 1'b1;
  localparam int unsigned CfgDataW = LimitW;

  // One result item
  typedef struct packed {
    logic             timed_out;
    logic [WordW-1:0] check_word;
    logic [WordW-1:0] signature;
    logic [WordW-1:0] center_x;
    logic [WordW-1:0] center_y;
    logic [WordW-1:0] obj_width;
    logic [WordW-1:0] obj_height;
    logic [WordW-1:0] obj_angle;
  } res_t;

endpackage

### sv/cofp_if.sv
// Valid/ready channel interfaces of the frame parser: byte input and result output.
// Depends on cofp_pkg.
interface cofp_in_if;
  logic                     valid;
  logic                     ready;
  logic [cofp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cofp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       timed_out;
  logic [cofp_pkg::WordW-1:0] check_word;
  logic [cofp_pkg::WordW-1:0] signature;
  logic [cofp_pkg::WordW-1:0] center_x;
  logic [cofp_pkg::WordW-1:0] center_y;
  logic [cofp_pkg::WordW-1:0] obj_width;
  logic [cofp_pkg::WordW-1:0] obj_height;
  logic [cofp_pkg::WordW-1:0] obj_angle;

  modport source (output valid, output timed_out, output check_word, output signature,
                  output center_x, output center_y, output obj_width, output obj_height,
                  output obj_angle, input ready);
  modport sink   (input valid, input timed_out, input check_word, input signature,
                  input center_x, input center_y, input obj_width, input obj_height,
                  input obj_angle, output ready);
endinterface

### sv/camera_object_frame_parser.sv
// Top level of the camera object frame parser: sync hunt, payload word
// collection, attempt counter and a two-entry result buffer.
// Depends on cofp_pkg, cofp_if.sv and camera_object_frame_parser_defines.svh.
//
//  channel   dir   handshake        payload
//  rx_i      in    valid / ready    rx_byte (8)
//  res_o     out   valid / ready    timed_out, 7 x 16-bit words
//  cfg       in    cfg_we_i         cfg_idx_i (1), cfg_data_i (6)
//
// One byte is taken per cycle while rx_i.ready is high; each byte settles in
// the cycle it is accepted; its result, if any, goes to out_q or skid_q.
// rx_i.ready depends only on the skid register: bytes keep flowing while one
// result waits, and stall only when a second result is held.
// Reset clears the hunt state, the attempt count and both result slots;
// frame_mode resets to 0 and attempt_limit to 50. No clearing pass.
`include "camera_object_frame_parser_defines.svh"

module camera_object_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cofp_in_if.sink                       rx_i,
  cofp_out_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [cofp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cofp_pkg::CfgDataW-1:0] cfg_data_i
);
  import cofp_pkg::*;

  // Hunt phase codes
  localparam logic [2:0] PH_SYNC0   = 3'd0;
  localparam logic [2:0] PH_SYNC1   = 3'd1;
  localparam logic [2:0] PH_SYNC2   = 3'd2;
  localparam logic [2:0] PH_SYNC3   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic              mode_q;
  logic [LimitW-1:0] limit_q;

  logic [2:0]        phase_q, phase_d;
  logic [3:0]        idx_q, idx_d;
  logic [ByteW-1:0]  hold_q, hold_d;
  logic [LimitW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0]  store_q [NumWords];

  res_t out_q, skid_q, res_new;
  logic out_valid_q, skid_valid_q;

  logic              accept, emit, wr_en, last_word;
  logic [ByteW-1:0]  exp_byte;
  logic [LimitW-1:0] lim, cnt_inc;
  logic [2:0]        w_sel, words;
  logic [WordW-1:0]  new_word;
  logic [WordW-1:0]  word [NumWords];

  assign accept = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !skid_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_MODE:    mode_q  <= cfg_data_i[0];
        REG_ATTEMPT_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derived values
  assign lim      = (limit_q == '0) ? LimitW'(1) : limit_q;
  assign cnt_inc  = cnt_q + LimitW'(1);
  assign w_sel    = (idx_q[3:1] == 3'd7) ? 3'd6 : idx_q[3:1];
  assign words    = mode_q ? 3'd7 : 3'd6;
  assign new_word = {rx_i.rx_byte, hold_q};
  assign last_word = (w_sel + 3'd1) >= words;

  // Expected sync byte per phase
  always_comb begin
    unique case (phase_q)
      PH_SYNC0: exp_byte = SYNC_A;
      PH_SYNC1: exp_byte = SYNC_B;
      PH_SYNC2: exp_byte = mode_q ? SYNC_CODE : SYNC_A;
      PH_SYNC3: exp_byte = SYNC_B;
      default:  exp_byte = SYNC_A;
    endcase
  end

  // Word view with the word written this cycle bypassed in
  always_comb begin
    for (int j = 0; j < NumWords; j++) begin
      word[j] = (wr_en && (w_sel == 3'(j))) ? new_word : store_q[j];
    end
  end

  // Per-byte state update and result build
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    hold_d  = hold_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    emit    = 1'b0;
    res_new = '0;
    if (accept) begin
      if (phase_q < PH_PAYLOAD) begin
        if (rx_i.rx_byte != exp_byte) begin
          // failed attempt
          phase_d = PH_SYNC0;
          if ((cnt_inc == '0) || (cnt_inc >= lim)) begin
            cnt_d             = '0;
            emit              = 1'b1;
            res_new.timed_out = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          phase_d = phase_q + 3'd1;
          if (phase_q == PH_SYNC3) idx_d = '0;
        end
      end else if (!idx_q[0]) begin
        hold_d = rx_i.rx_byte;
        idx_d  = idx_q + 4'd1;
      end else begin
        wr_en = 1'b1;
        idx_d = idx_q + 4'd1;
        if (last_word) begin
          phase_d = PH_SYNC0;
          idx_d   = '0;
          cnt_d   = '0;
          emit    = 1'b1;
        end
      end
    end
    if (emit && !res_new.timed_out) begin
      res_new.check_word = word[0];
      res_new.signature  = word[1];
      res_new.center_x   = word[2];
      res_new.center_y   = word[3];
      res_new.obj_width  = word[4];
      res_new.obj_height = word[5];
      res_new.obj_angle  = mode_q ? word[6] : '0;
    end
  end

  // Hunt state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC0;
      idx_q   <= '0;
      hold_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      hold_q  <= hold_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload word store, every entry written before it is read
  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[w_sel] <= new_word;
  end

  // Output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q) begin
      out_valid_q <= emit;
    end else if (res_o.ready) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= emit;
      end
    end else if (emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || res_o.ready) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end
    if (out_valid_q && !res_o.ready && emit) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.timed_out  = out_q.timed_out;
  assign res_o.check_word = out_q.check_word;
  assign res_o.signature  = out_q.signature;
  assign res_o.center_x   = out_q.center_x;
  assign res_o.center_y   = out_q.center_y;
  assign res_o.obj_width  = out_q.obj_width;
  assign res_o.obj_height = out_q.obj_height;
  assign res_o.obj_angle  = out_q.obj_angle;

  // Checks
  `COFP_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `COFP_ASSERT_NEXT(a_emit_shows, emit && !out_valid_q, out_valid_q, "result not registered")
  `COFP_ASSERT_NOW(a_timeout_zero, out_valid_q && out_q.timed_out,
    (out_q.check_word == '0) && (out_q.center_x == '0) && (out_q.obj_angle == '0),
    "timeout result carries data")
  `COFP_ASSERT_NOW(a_cnt_below_max, 1'b1, cnt_q != '1, "attempt count at its maximum")
  `COFP_ASSERT_NOW(a_idx_range, phase_q == PH_PAYLOAD, idx_q <= 4'd13,
    "payload index past last word")

endmodule
